// ===== design/fbfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fbfa_pkg;

  localparam int CFG_W = 21;
  localparam int DEF_MAX_BLOCKS = 64;
  localparam int DEF_ADDR_BITS = 20;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_REINIT = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_BADOFF = 2'd2;
  localparam logic [1:0] ST_ZERO   = 2'd3;

  localparam logic [1:0] REG_FIT_MODE     = 2'd0;
  localparam logic [1:0] REG_SPLIT_MIN    = 2'd1;
  localparam logic [1:0] REG_REGION_BYTES = 2'd2;

  localparam logic [CFG_W-1:0] RST_SPLIT_MIN    = CFG_W'(32);
  localparam logic [CFG_W-1:0] RST_REGION_BYTES = CFG_W'(1048576);

  typedef struct packed {
    logic             fit_mode;
    logic [CFG_W-1:0] split_min;
    logic [CFG_W-1:0] region_bytes;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/fbfa_table_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fbfa_table_mem #(
  parameter int DEPTH = 64,
  parameter int EW = 42,
  parameter int IW = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [IW-1:0] waddr,
  input  wire logic [EW-1:0] wdata,
  input  wire logic [IW-1:0] raddr,
  output logic      [EW-1:0] rdata
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/fbfa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fbfa_ctrl
  import fbfa_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int ADDR_BITS = DEF_ADDR_BITS,
  localparam int SW = ADDR_BITS + 1,
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  localparam int CNTW = $clog2(MAX_BLOCKS + 1),
  localparam int EW = 1 + SW + ADDR_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfg_t                 cfg,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire logic [1:0]           op,
  input  wire logic [SW-1:0]        req_size,
  input  wire logic [ADDR_BITS-1:0] block_offset,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output logic      [1:0]           status,
  output logic      [ADDR_BITS-1:0] grant_offset,
  output logic      [CNTW-1:0]      used_blocks,
  output logic      [SW-1:0]        free_bytes,
  output logic      [CNTW-1:0]      free_count,
  output logic                      mem_we,
  output logic      [IW-1:0]        mem_waddr,
  output logic      [EW-1:0]        mem_wdata,
  output logic      [IW-1:0]        mem_raddr,
  input  wire logic [EW-1:0]        mem_rdata
);

  localparam int CW = (SW > CFG_W) ? SW : CFG_W;
  localparam logic [CW-1:0] LIM = CW'(1) << ADDR_BITS;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_REINIT = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_SHIFT  = 4'd4;
  localparam logic [3:0] S_WR1    = 4'd5;
  localparam logic [3:0] S_WR2    = 4'd6;
  localparam logic [3:0] S_RESP   = 4'd7;

  logic [3:0] state;
  logic boot;
  logic [1:0] op_r;
  logic [SW-1:0] req_r;
  logic [ADDR_BITS-1:0] off_r;
  logic [CNTW-1:0] scan_idx;
  logic rd_valid;
  logic [IW-1:0] rd_idx;
  logic found;
  logic [IW-1:0] pick_idx;
  logic [ADDR_BITS-1:0] pick_off;
  logic [SW-1:0] pick_size;
  logic pick_free;
  logic last_free, prev_free, next_got, next_free;
  logic [SW-1:0] last_size, prev_size, next_size;
  logic [ADDR_BITS-1:0] last_off, prev_off;
  logic [IW-1:0] sh_src;
  logic [CNTW-1:0] sh_cnt;
  logic sh_up;
  logic [1:0] sh_n;
  logic wr1_en, wr2_en;
  logic [IW-1:0] wr1_addr, wr2_addr;
  logic [EW-1:0] wr1_data, wr2_data;
  logic [CNTW-1:0] blk_count, used_count, free_entries;
  logic [SW-1:0] free_total;
  logic [1:0] res_status;
  logic [ADDR_BITS-1:0] res_grant;

  logic e_free;
  logic [SW-1:0] e_size;
  logic [ADDR_BITS-1:0] e_off;
  logic [CW-1:0] cap_w;
  logic [SW-1:0] cap;
  logic [SW-1:0] leftover;
  logic [CW-1:0] smin;
  logic split;
  logic nf, pf;
  logic [1:0] mcnt;
  logic [CNTW-1:0] at_c, p_c;
  logic [SW-1:0] merged;

  assign {e_free, e_size, e_off} = mem_rdata;

  always_comb begin
    cap_w = ({{(CW-CFG_W){1'b0}}, cfg.region_bytes} > LIM) ? LIM
          : {{(CW-CFG_W){1'b0}}, cfg.region_bytes};
    cap = cap_w[SW-1:0];
    leftover = pick_size - req_r;
    smin = (cfg.split_min == '0) ? CW'(1) : {{(CW-CFG_W){1'b0}}, cfg.split_min};
    split = ({{(CW-SW){1'b0}}, leftover} >= smin) && (blk_count < CNTW'(MAX_BLOCKS));
    at_c = {{(CNTW-IW){1'b0}}, pick_idx};
    nf = next_got && next_free;
    pf = (pick_idx != '0) && prev_free;
    mcnt = {1'b0, nf} + {1'b0, pf};
    p_c = pf ? at_c : at_c + CNTW'(1);
    merged = pick_size + (nf ? next_size : '0) + (pf ? prev_size : '0);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    case (state)
      S_REINIT: begin
        mem_we = (cap != '0);
        mem_wdata = {1'b1, cap, {ADDR_BITS{1'b0}}};
      end
      S_SCAN: mem_raddr = scan_idx[IW-1:0];
      S_SHIFT: begin
        mem_raddr = sh_src;
        mem_we = rd_valid;
        mem_waddr = sh_up ? rd_idx + IW'(1) : rd_idx - IW'(sh_n);
        mem_wdata = mem_rdata;
      end
      S_WR1: begin
        mem_we = wr1_en;
        mem_waddr = wr1_addr;
        mem_wdata = wr1_data;
      end
      S_WR2: begin
        mem_we = wr2_en;
        mem_waddr = wr2_addr;
        mem_wdata = wr2_data;
      end
      default: ;
    endcase
  end

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_REINIT;
      boot <= 1'b1;
      rd_valid <= 1'b0;
      rsp_valid <= 1'b0;
      blk_count <= '0;
      used_count <= '0;
      free_entries <= '0;
      free_total <= '0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_RESP) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_r <= op;
            req_r <= req_size;
            off_r <= block_offset;
            scan_idx <= '0;
            found <= 1'b0;
            next_got <= 1'b0;
            rd_valid <= 1'b0;
            res_status <= (op == OP_ALLOC && req_size == '0) ? ST_ZERO : ST_OK;
            res_grant <= '0;
            boot <= 1'b0;
            if (op == OP_REINIT) begin
              state <= S_REINIT;
            end else if (op == OP_FREE) begin
              state <= S_SCAN;
            end else if (op == OP_ALLOC) begin
              if (req_size == '0) begin
                state <= S_RESP;
              end else begin
                state <= S_SCAN;
              end
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_REINIT: begin
          used_count <= '0;
          if (cap == '0) begin
            blk_count <= '0;
            free_total <= '0;
            free_entries <= '0;
          end else begin
            blk_count <= CNTW'(1);
            free_total <= cap;
            free_entries <= CNTW'(1);
          end
          state <= boot ? S_IDLE : S_RESP;
        end
        S_SCAN: begin
          if (scan_idx < blk_count) begin
            rd_valid <= 1'b1;
            rd_idx <= scan_idx[IW-1:0];
            scan_idx <= scan_idx + CNTW'(1);
          end else begin
            rd_valid <= 1'b0;
            if (!rd_valid) begin
              state <= S_DECIDE;
            end
          end
          if (rd_valid) begin
            last_free <= e_free;
            last_size <= e_size;
            last_off <= e_off;
            if (op_r == OP_ALLOC) begin
              if (e_free && e_size >= req_r &&
                  (!found || (cfg.fit_mode && pick_size > e_size))) begin
                found <= 1'b1;
                pick_idx <= rd_idx;
                pick_off <= e_off;
                pick_size <= e_size;
              end
            end else begin
              if (!found && e_off == off_r) begin
                found <= 1'b1;
                pick_idx <= rd_idx;
                pick_off <= e_off;
                pick_size <= e_size;
                pick_free <= e_free;
                prev_free <= last_free;
                prev_size <= last_size;
                prev_off <= last_off;
              end else if (found && {1'b0, rd_idx} == {1'b0, pick_idx} + 1'b1) begin
                next_got <= 1'b1;
                next_free <= e_free;
                next_size <= e_size;
              end
            end
          end
        end
        S_DECIDE: begin
          if (op_r == OP_ALLOC) begin
            if (!found) begin
              res_status <= ST_NOFIT;
              state <= S_RESP;
            end else begin
              state <= S_SHIFT;
              used_count <= used_count + CNTW'(1);
              res_grant <= pick_off;
              wr2_en <= 1'b1;
              wr2_addr <= pick_idx;
              if (split) begin
                sh_up <= 1'b1;
                sh_src <= IW'(blk_count - CNTW'(1));
                sh_cnt <= blk_count - at_c - CNTW'(1);
                wr1_en <= 1'b1;
                wr1_addr <= pick_idx + IW'(1);
                wr1_data <= {1'b1, leftover, pick_off + req_r[ADDR_BITS-1:0]};
                wr2_data <= {1'b0, req_r, pick_off};
                blk_count <= blk_count + CNTW'(1);
                free_total <= free_total - req_r;
              end else begin
                sh_cnt <= '0;
                wr1_en <= 1'b0;
                wr2_data <= {1'b0, pick_size, pick_off};
                free_entries <= free_entries - CNTW'(1);
                free_total <= free_total - pick_size;
              end
            end
          end else begin
            if (!found || pick_free) begin
              res_status <= ST_BADOFF;
              state <= S_RESP;
            end else begin
              state <= S_SHIFT;
              wr2_en <= 1'b0;
              used_count <= used_count - CNTW'(1);
              free_total <= free_total + pick_size;
              free_entries <= free_entries + CNTW'(1) - CNTW'(mcnt);
              blk_count <= blk_count - CNTW'(mcnt);
              sh_up <= 1'b0;
              sh_n <= mcnt;
              sh_src <= IW'(p_c + CNTW'(mcnt));
              sh_cnt <= (mcnt == 2'd0) ? '0 : blk_count - p_c - CNTW'(mcnt);
              wr1_en <= 1'b1;
              wr1_addr <= pf ? pick_idx - IW'(1) : pick_idx;
              wr1_data <= {1'b1, merged, pf ? prev_off : pick_off};
            end
          end
        end
        S_SHIFT: begin
          if (sh_cnt != '0) begin
            rd_valid <= 1'b1;
            rd_idx <= sh_src;
            sh_src <= sh_up ? sh_src - IW'(1) : sh_src + IW'(1);
            sh_cnt <= sh_cnt - CNTW'(1);
          end else begin
            rd_valid <= 1'b0;
            if (!rd_valid) begin
              state <= S_WR1;
            end
          end
        end
        S_WR1: state <= S_WR2;
        S_WR2: state <= S_RESP;
        S_RESP: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            status <= res_status;
            grant_offset <= res_grant;
            used_blocks <= used_count;
            free_bytes <= free_total;
            free_count <= free_entries;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/first_best_fit_block_allocator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// First/best fit block allocator with coalescing.
// Request channel: req_valid / req_stall carry one beat of op, req_size and
// block_offset. Op allocate finds a free block (first fit, or best fit when
// fit_mode is set), free releases the block at block_offset and merges it
// with free neighbours, reinit rebuilds the table as one free block.
// Response channel: rsp_valid / rsp_stall carry one beat per request with
// status, grant_offset and the usage counters after the request.
// The block table lives in one synchronous RAM (one read, one write port).
// An allocate or free runs a pipelined scan of all entries and then, unless
// it fails, a shift of the entries behind a split or merge point and two
// entry writes. A reinit, a zero size or an unused op skips the scan; a
// reinit leaves the table empty when the region size is zero.
// One request is in flight at a time; req_stall is high while it runs.
// A finished response sits in the output register, so the next request is
// taken while the receiver stalls; a second response waits in the sequencer.
// Reset: synchronous, active high. Registers take their reset values, then
// a reinit writes entry 0 of the table while req_stall is high.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken at any edge.
module first_best_fit_block_allocator_unit
  import fbfa_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int ADDR_BITS = DEF_ADDR_BITS,
  localparam int SW = ADDR_BITS + 1,
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  localparam int CNTW = $clog2(MAX_BLOCKS + 1),
  localparam int EW = 1 + SW + ADDR_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire logic [1:0]           op,
  input  wire logic [SW-1:0]        req_size,
  input  wire logic [ADDR_BITS-1:0] block_offset,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output logic      [1:0]           status,
  output logic      [ADDR_BITS-1:0] grant_offset,
  output logic      [CNTW-1:0]      used_blocks,
  output logic      [SW-1:0]        free_bytes,
  output logic      [CNTW-1:0]      free_count
);

  cfg_t cfg;
  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  // Configuration registers; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fit_mode <= 1'b0;
      cfg.split_min <= RST_SPLIT_MIN;
      cfg.region_bytes <= RST_REGION_BYTES;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIT_MODE:     cfg.fit_mode <= cfg_data[0];
        REG_SPLIT_MIN:    cfg.split_min <= cfg_data;
        REG_REGION_BYTES: cfg.region_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: scan, shift and write back the table.
  fbfa_ctrl #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .ADDR_BITS(ADDR_BITS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .op(op),
    .req_size(req_size),
    .block_offset(block_offset),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status(status),
    .grant_offset(grant_offset),
    .used_blocks(used_blocks),
    .free_bytes(free_bytes),
    .free_count(free_count),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  // Block table: {free, size, offset} per entry, kept in address order.
  fbfa_table_mem #(
    .DEPTH(MAX_BLOCKS),
    .EW(EW),
    .IW(IW)
  ) u_table (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule
`default_nettype wire

// ===== tb/alloc_checker.sv =====
`timescale 1ns / 1ps
module alloc_checker
  import fbfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             req_valid,
  input  logic             req_stall,
  input  logic [1:0]       op,
  input  logic [20:0]      req_size,
  input  logic [19:0]      block_offset,
  input  logic             rsp_valid,
  input  logic             rsp_stall,
  input  logic [1:0]       status,
  input  logic [19:0]      grant_offset,
  input  logic [6:0]       used_blocks,
  input  logic [20:0]      free_bytes,
  input  logic [6:0]       free_count,
  output int               mismatches,
  output int               pending
);

  localparam int NBLK = 64;
  localparam int SPAN = 1 << 20;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] grant;
    logic [6:0]  used;
    logic [20:0] fbytes;
    logic [6:0]  fcount;
  } alloc_rsp_t;

  alloc_rsp_t expected_rsp[$];

  logic        mode_best;
  logic [20:0] min_split;
  logic [20:0] region_len;

  logic [19:0] tab_off[NBLK];
  logic [20:0] tab_len[NBLK];
  bit          tab_free[NBLK];
  int          tab_cnt, n_used, bytes_free, n_free;

  task automatic rebuild_table();
    int cap;
    cap = (int'(region_len) > SPAN) ? SPAN : int'(region_len);
    for (int k = 0; k < NBLK; k++) begin
      tab_off[k] = '0;
      tab_len[k] = '0;
      tab_free[k] = 0;
    end
    n_used = 0;
    if (cap == 0) begin
      tab_cnt = 0;
      bytes_free = 0;
      n_free = 0;
    end else begin
      tab_cnt = 1;
      tab_len[0] = 21'(cap);
      tab_free[0] = 1;
      bytes_free = cap;
      n_free = 1;
    end
  endtask

  task automatic drop_entry(int at);
    for (int k = at; k + 1 < tab_cnt; k++) begin
      tab_off[k] = tab_off[k+1];
      tab_len[k] = tab_len[k+1];
      tab_free[k] = tab_free[k+1];
    end
    tab_cnt--;
  endtask

  task automatic grant_block(int req, output logic [1:0] st, output logic [19:0] grant);
    int  pick, spare, smin;
    bit  hit;
    pick = 0;
    hit = 0;
    grant = '0;
    if (req == 0) begin
      st = ST_ZERO;
      return;
    end
    for (int i = 0; i < tab_cnt; i++) begin
      if (!tab_free[i] || int'(tab_len[i]) < req) continue;
      if (!hit || (mode_best && tab_len[pick] > tab_len[i])) begin
        pick = i;
        hit = 1;
        if (!mode_best) break;
      end
    end
    if (!hit) begin
      st = ST_NOFIT;
      return;
    end
    tab_free[pick] = 0;
    spare = int'(tab_len[pick]) - req;
    smin = (min_split == 0) ? 1 : int'(min_split);
    if (spare >= smin && tab_cnt < NBLK) begin
      // open a slot behind the pick for the split-off tail
      for (int k = tab_cnt; k > pick + 1; k--) begin
        tab_off[k] = tab_off[k-1];
        tab_len[k] = tab_len[k-1];
        tab_free[k] = tab_free[k-1];
      end
      tab_off[pick+1] = 20'(int'(tab_off[pick]) + req);
      tab_len[pick+1] = 21'(spare);
      tab_free[pick+1] = 1;
      tab_cnt++;
      tab_len[pick] = 21'(req);
    end else begin
      n_free--;
    end
    bytes_free -= int'(tab_len[pick]);
    n_used++;
    grant = tab_off[pick];
    st = ST_OK;
  endtask

  task automatic release_block(logic [19:0] off, output logic [1:0] st);
    int at;
    at = -1;
    for (int i = 0; i < tab_cnt; i++) begin
      if (tab_off[i] == off) begin
        at = i;
        break;
      end
    end
    if (at < 0 || tab_free[at]) begin
      st = ST_BADOFF;
      return;
    end
    tab_free[at] = 1;
    bytes_free += int'(tab_len[at]);
    n_used--;
    n_free++;
    if (at + 1 < tab_cnt && tab_free[at+1]) begin
      tab_len[at] = tab_len[at] + tab_len[at+1];
      drop_entry(at + 1);
      n_free--;
    end
    if (at > 0 && tab_free[at-1]) begin
      tab_len[at-1] = tab_len[at-1] + tab_len[at];
      drop_entry(at);
      n_free--;
    end
    st = ST_OK;
  endtask

  task automatic predict_beat(logic [1:0] cmd, logic [20:0] sz, logic [19:0] off);
    alloc_rsp_t r;
    logic [1:0]  st;
    logic [19:0] g;
    st = ST_OK;
    g = '0;
    case (cmd)
      OP_ALLOC:  grant_block(int'(sz), st, g);
      OP_FREE:   release_block(off, st);
      OP_REINIT: rebuild_table();
      default: ;
    endcase
    r.status = st;
    r.grant = (st == ST_OK && cmd == OP_ALLOC) ? g : '0;
    r.used = 7'(n_used);
    r.fbytes = 21'(bytes_free);
    r.fcount = 7'(n_free);
    expected_rsp.push_back(r);
  endtask

  task automatic report(string field, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  initial mismatches = 0;
  assign pending = expected_rsp.size();

  always @(posedge clk) begin
    alloc_rsp_t w;
    if (rst) begin
      mode_best = 0;
      min_split = RST_SPLIT_MIN;
      region_len = RST_REGION_BYTES;
      rebuild_table();
      expected_rsp.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FIT_MODE:     mode_best = cfg_data[0];
          REG_SPLIT_MIN:    min_split = cfg_data;
          REG_REGION_BYTES: region_len = cfg_data;
          default: ;
        endcase
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          report("unexpected response beat", status, 0);
        end else begin
          w = expected_rsp.pop_front();
          if (status !== w.status) report("status", status, w.status);
          if (grant_offset !== w.grant) report("grant_offset", grant_offset, w.grant);
          if (used_blocks !== w.used) report("used_blocks", used_blocks, w.used);
          if (free_bytes !== w.fbytes) report("free_bytes", free_bytes, w.fbytes);
          if (free_count !== w.fcount) report("free_count", free_count, w.fcount);
        end
      end
      if (req_valid && !req_stall) predict_beat(op, req_size, block_offset);
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import fbfa_pkg::*;

  // op code 3 is unused by the block; it must leave the table alone
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_WAIT = 160;
  localparam int SQUEEZE_LEN = 400;
  localparam int NPHASE = 8;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             req_valid;
  logic             req_stall;
  logic [1:0]       op;
  logic [20:0]      req_size;
  logic [19:0]      block_offset;
  logic             rsp_valid;
  logic             rsp_stall;
  logic [1:0]       status;
  logic [19:0]      grant_offset;
  logic [6:0]       used_blocks;
  logic [20:0]      free_bytes;
  logic [6:0]       free_count;

  int mismatches, pending;
  int beats_in, beats_out, idle_cycles;
  bit squeeze;

  logic [1:0]  ops_in_flight[$];
  logic [19:0] live_grants[$];

  // per-phase register settings: fit mode, split minimum, region size
  logic        ph_mode[NPHASE]   = '{0, 1, 0, 1, 0, 1, 0, 1};
  int          ph_split[NPHASE]  = '{32, 1, 1048576, 0, 8, 16, 4, 2};
  int          ph_region[NPHASE] = '{1048576, 4096, 1048576, 2097151, 1, 0, 65536, 200000};
  int          ph_items[NPHASE]  = '{110, 130, 110, 120, 30, 30, 200, 140};

  first_best_fit_block_allocator_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall),
    .op(op), .req_size(req_size), .block_offset(block_offset),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .grant_offset(grant_offset), .used_blocks(used_blocks),
    .free_bytes(free_bytes), .free_count(free_count)
  );

  alloc_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall),
    .op(op), .req_size(req_size), .block_offset(block_offset),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .grant_offset(grant_offset), .used_blocks(used_blocks),
    .free_bytes(free_bytes), .free_count(free_count),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Track beats on both channels: remember granted offsets so that frees
  // can target live blocks, and feed the watchdog.
  always @(posedge clk) begin
    logic [1:0] sent_op;
    if (rst) begin
      beats_in <= 0;
      beats_out <= 0;
      idle_cycles <= 0;
    end else begin
      if (req_valid && !req_stall) begin
        ops_in_flight.push_back(op);
        beats_in <= beats_in + 1;
      end
      if (rsp_valid && !rsp_stall) begin
        beats_out <= beats_out + 1;
        if (ops_in_flight.size() > 0) begin
          sent_op = ops_in_flight.pop_front();
          if (sent_op == OP_ALLOC && status == ST_OK) live_grants.push_back(grant_offset);
        end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == IDLE_LIMIT) begin
        $display("first_best_fit_block_allocator_unit test failed");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver back-pressure: short random bursts, an occasional long one,
  // and a single long hold-off when the stimulus asks for it.
  initial begin
    int len;
    rsp_stall = 1'b0;
    squeeze = 0;
    forever begin
      if (squeeze) begin
        rsp_stall <= 1'b1;
        repeat (SQUEEZE_LEN) @(posedge clk);
        squeeze = 0;
      end else begin
        rsp_stall <= ($urandom_range(0, 3) == 0);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
        repeat (len) @(posedge clk);
      end
    end
  end

  // Offer one beat and hold it until taken; then idle for a random gap.
  task automatic send_beat(logic [1:0] cmd, logic [20:0] sz, logic [19:0] off);
    int g;
    req_valid <= 1'b1;
    op <= cmd;
    req_size <= sz;
    block_offset <= off;
    do @(posedge clk); while (req_stall);
    g = pick_gap();
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    if (cmd == OP_REINIT) live_grants.delete();
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
  endtask

  // Hold until every response is back, then let the block settle.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (beats_out != beats_in) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic random_beat(int region);
    int r, k, cap;
    logic [20:0] sz;
    logic [19:0] off;
    cap = (region > 1048576) ? 1048576 : region;
    off = 20'($urandom);
    r = $urandom_range(0, 99);
    if (r < 10) begin
      sz = 21'($urandom);
    end else if (r < 15) begin
      sz = '0;
    end else if (r < 30) begin
      sz = 21'($urandom_range(1, (cap > 0) ? cap : 1));
    end else begin
      sz = 21'($urandom_range(1, (cap / 60 > 1) ? cap / 60 : 1));
    end
    r = $urandom_range(0, 99);
    if (r < 58) begin
      send_beat(OP_ALLOC, sz, off);
    end else if (r < 88 && live_grants.size() > 0) begin
      k = $urandom_range(0, live_grants.size() - 1);
      off = live_grants[k];
      live_grants.delete(k);
      send_beat(OP_FREE, sz, off);
    end else if (r < 94) begin
      send_beat(OP_FREE, sz, off);
    end else if (r < 97) begin
      send_beat(OP_SPARE, sz, off);
    end else begin
      send_beat(OP_REINIT, sz, off);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_FIT_MODE;
    cfg_data = '0;
    req_valid = 1'b0;
    op = OP_ALLOC;
    req_size = '0;
    block_offset = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < NPHASE; p++) begin
      drain();
      write_reg(REG_FIT_MODE, int'(ph_mode[p]));
      write_reg(REG_SPLIT_MIN, ph_split[p]);
      write_reg(REG_REGION_BYTES, ph_region[p]);
      cfg_we <= 1'b0;
      // the region size only takes effect on a reinit
      send_beat(OP_REINIT, 21'($urandom), 20'($urandom));

      if (p == 0) begin
        send_beat(OP_ALLOC, 21'd0, 20'hFFFFF);
        send_beat(OP_ALLOC, 21'd1, 20'd0);
        send_beat(OP_ALLOC, 21'h1FFFFF, 20'd0);
        send_beat(OP_FREE, 21'h1FFFFF, 20'hFFFFF);
        send_beat(OP_FREE, 21'd0, 20'd0);
        send_beat(OP_FREE, 21'd0, 20'd0);
        send_beat(OP_ALLOC, 21'd1048576, 20'd0);
        send_beat(OP_ALLOC, 21'd1, 20'd0);
        send_beat(OP_FREE, 21'd0, 20'd0);
        send_beat(OP_ALLOC, 21'd100, 20'd0);
        send_beat(OP_ALLOC, 21'd200, 20'd0);
        send_beat(OP_ALLOC, 21'd300, 20'd0);
        send_beat(OP_FREE, 21'd0, 20'd100);
        send_beat(OP_FREE, 21'd0, 20'd300);
        send_beat(OP_FREE, 21'd0, 20'd0);
        send_beat(OP_ALLOC, 21'd1048545, 20'd0);
        send_beat(OP_FREE, 21'd0, 20'd0);
        send_beat(OP_SPARE, 21'h1FFFFF, 20'hFFFFF);
        send_beat(OP_REINIT, 21'h1FFFFF, 20'hFFFFF);
        send_beat(OP_SPARE, 21'd0, 20'd0);
      end

      // the small region with a tiny split minimum fills the table
      if (p == 6) squeeze = 1;
      for (int n = 0; n < ph_items[p]; n++) random_beat(ph_region[p]);
    end

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("first_best_fit_block_allocator_unit test passed");
    end else begin
      $display("first_best_fit_block_allocator_unit test failed");
    end
    $finish;
  end

endmodule
